// ----- rtl/htfe_pkg.sv -----
// htfe_pkg: shared constants and types for the head/tail frame extractor
// no dependencies; imported by htfe_regs and head_tail_frame_extractor_unit
`default_nettype none

package htfe_pkg;

  // frame buffer and marker geometry
  localparam int unsigned BufDepth  = 1048576;
  localparam int unsigned HeadLen   = 6;
  localparam int unsigned TailLen   = 4;
  localparam int unsigned AddrW     = 20;
  localparam int unsigned LenW      = 21;
  localparam int unsigned CntW      = 3;
  localparam int unsigned HeadW     = 8 * HeadLen;
  localparam int unsigned TailW     = 8 * TailLen;

  // apb register map
  localparam int unsigned PaddrW    = 4;
  localparam int unsigned PdataW    = 64;
  localparam logic        RegHead   = 1'b0;
  localparam logic        RegTail   = 1'b1;

  localparam logic [HeadW-1:0] HeadReset = 48'h6579_6564_6561;
  localparam logic [TailW-1:0] TailReset = 32'h4552_5653;

  typedef struct packed {
    logic [HeadW-1:0] head_pattern;
    logic [TailW-1:0] tail_pattern;
  } htfe_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/htfe_regs.sv -----
// htfe_regs: apb configuration registers (head and tail patterns)
// depends on htfe_pkg
`default_nettype none

module htfe_regs
  import htfe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready,
  output htfe_cfg_t              cfg_o
);

  logic       wr_en;
  logic       reg_sel;
  htfe_cfg_t  cfg_q;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  // register index sits on address bit 3 (8-byte spacing)
  assign reg_sel = paddr[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.head_pattern <= HeadReset;
      cfg_q.tail_pattern <= TailReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegHead: cfg_q.head_pattern <= pwdata[HeadW-1:0];
        RegTail: cfg_q.tail_pattern <= pwdata[TailW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegHead: prdata = {{(PdataW-HeadW){1'b0}}, cfg_q.head_pattern};
      RegTail: prdata = {{(PdataW-TailW){1'b0}}, cfg_q.tail_pattern};
      default: prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/head_tail_frame_extractor_unit.sv -----
// head_tail_frame_extractor_unit: top level of the head/tail frame extractor
// depends on htfe_pkg and htfe_regs
//
// channel | direction | payload                                   | handshake
// in      | input     | byte_in, chunk_end                        | in_valid_i / in_stall_o
// out     | output    | write_enable/address/data, frame_done,    | out_valid_o / out_stall_i
//         |           | frame_length, overflow_error              |
// cfg     | input     | apb, 64-bit data, regs at 0x0 and 0x8     | psel/penable, pready=1
//
// one byte per cycle sustained while the result is not stalled
// the byte sits in an input register, then one pass of head/tail logic fills the result register
// the match count, store index and last-four shift register update as the result register loads
// reset clears all control state and loads the default head and tail patterns
// a stalled result holds the input register; one more byte is still taken if that register was empty
`default_nettype none

module head_tail_frame_extractor_unit
  import htfe_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        byte_in_i,
  input  wire logic              chunk_end_i,
  // output channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   write_enable_o,
  output logic      [AddrW-1:0]  write_address_o,
  output logic      [7:0]        write_data_o,
  output logic                   frame_done_o,
  output logic      [LenW-1:0]   frame_length_o,
  output logic                   overflow_error_o,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [PdataW-1:0] pwdata,
  output logic      [PdataW-1:0] prdata,
  output logic                   pready
);

  htfe_cfg_t cfg;

  htfe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       in_xfer;
  logic       advance;   // input register moves into the result register

  // frame state
  logic [CntW-1:0]  match_cnt_q, match_cnt_d;
  logic [LenW-1:0]  store_idx_q, store_idx_d;
  logic [TailW-1:0] last4_q, last4_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic             we_q, we_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [7:0]       data_q, data_d;
  logic             done_q, done_d;
  logic [LenW-1:0]  len_q, len_d;
  logic             ovf_q, ovf_d;

  // per-byte logic
  logic [7:0]       head_byte;
  logic             storing;
  logic [LenW-1:0]  idx_inc;
  logic [TailW-1:0] last4_shift;

  // result register frees when empty or when its transfer completes this cycle
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_xfer || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= byte_in_i;
      s1_last_q <= chunk_end_i;
    end
  end

  // head byte for the current match position, first byte in the top octet
  always_comb begin
    case (match_cnt_q)
      3'd0:    head_byte = cfg.head_pattern[47:40];
      3'd1:    head_byte = cfg.head_pattern[39:32];
      3'd2:    head_byte = cfg.head_pattern[31:24];
      3'd3:    head_byte = cfg.head_pattern[23:16];
      3'd4:    head_byte = cfg.head_pattern[15:8];
      3'd5:    head_byte = cfg.head_pattern[7:0];
      default: head_byte = '0;
    endcase
  end

  assign storing     = (match_cnt_q == CntW'(HeadLen));
  assign idx_inc     = store_idx_q + LenW'(1);
  assign last4_shift = {last4_q[TailW-9:0], s1_byte_q};

  always_comb begin
    match_cnt_d = match_cnt_q;
    store_idx_d = store_idx_q;
    last4_d     = last4_q;
    we_d        = 1'b0;
    addr_d      = '0;
    data_d      = '0;
    done_d      = 1'b0;
    len_d       = '0;
    ovf_d       = 1'b0;
    if (!storing) begin
      // hunt: a mismatching byte is dropped, not retried as a first head byte
      if (s1_byte_q == head_byte) begin
        match_cnt_d = match_cnt_q + CntW'(1);
      end else begin
        match_cnt_d = '0;
        store_idx_d = '0;
        last4_d     = '0;
      end
    end else if (store_idx_q >= LenW'(BufDepth)) begin
      // buffer full: drop the frame and go back to hunt
      ovf_d       = 1'b1;
      match_cnt_d = '0;
      store_idx_d = '0;
      last4_d     = '0;
    end else begin
      we_d        = 1'b1;
      addr_d      = store_idx_q[AddrW-1:0];
      data_d      = s1_byte_q;
      store_idx_d = idx_inc;
      last4_d     = last4_shift;
      // tail only checked on a stored chunk-end byte with more than the tail stored
      if (s1_last_q && (idx_inc > LenW'(TailLen)) && (last4_shift == cfg.tail_pattern)) begin
        done_d      = 1'b1;
        len_d       = idx_inc;
        match_cnt_d = '0;
        store_idx_d = '0;
        last4_d     = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_cnt_q <= '0;
      store_idx_q <= '0;
      last4_q     <= '0;
    end else if (advance) begin
      match_cnt_q <= match_cnt_d;
      store_idx_q <= store_idx_d;
      last4_q     <= last4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      we_q   <= we_d;
      addr_q <= addr_d;
      data_q <= data_d;
      done_q <= done_d;
      len_q  <= len_d;
      ovf_q  <= ovf_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign write_enable_o   = we_q;
  assign write_address_o  = addr_q;
  assign write_data_o     = data_q;
  assign frame_done_o     = done_q;
  assign frame_length_o   = len_q;
  assign overflow_error_o = ovf_q;

  // a completed frame is always the stored byte at its last address
  a_done_is_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> we_q && (len_q == ({1'b0, addr_q} + LenW'(1))))
    else $error("frame done without matching write");

  // an overflow never stores the byte
  a_ovf_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ovf_q |-> !we_q && !done_q)
    else $error("overflow result also writes");

  // frame end or overflow leaves the state back in hunt
  a_back_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (done_q || ovf_q) |-> (match_cnt_q == '0) && (store_idx_q == '0))
    else $error("state not cleared after frame end");

  // the index never runs past the buffer depth and the match count never past the head length
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (store_idx_q <= LenW'(BufDepth)) && (match_cnt_q <= CntW'(HeadLen)))
    else $error("frame state out of range");

  // the input register is held while the result is stalled
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && s1_valid_q |=> s1_valid_q && $stable(s1_byte_q))
    else $error("input register lost under stall");

endmodule

`default_nettype wire
